// ===== rtl/b58_pkg.sv =====
// Shared types, constants and the alphabet lookup of the Base58 encoder.
package b58_pkg;

  // Input request and output character payloads.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } b58_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
    logic       overflow;
  } b58_out_t;

  // Queue entry between front and back, tagged by the front.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
    logic       is_zero;
  } b58_item_t;

  typedef struct packed {
    logic      valid;
    b58_item_t item;
  } b58_q_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic emit_last;
    logic idle;
    logic store_empty;
  } b58_status_t;

  localparam int QDEPTH = 2;

  // value / 58 == (value * RECIP) >> RECIP_SHIFT for value < 16384
  localparam int RECIP       = 1130;
  localparam int RECIP_SHIFT = 16;

  localparam logic [6:0] CHAR_ONE = 7'h31;

  function automatic logic [6:0] b58_char(input logic [5:0] d);
    logic [6:0] dx;
    logic [6:0] ch;
    dx = {1'b0, d};
    case (d) inside
      [6'd0:6'd8]:   ch = dx + 7'd49;
      [6'd9:6'd16]:  ch = dx + 7'd56;
      [6'd17:6'd21]: ch = dx + 7'd57;
      [6'd22:6'd32]: ch = dx + 7'd58;
      [6'd33:6'd43]: ch = dx + 7'd64;
      [6'd44:6'd57]: ch = dx + 7'd65;
      default:       ch = CHAR_ONE;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/b58_stream_if.sv =====
// Valid/ready stream interface carrying one payload per request.
interface b58_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/b58_front.sv =====
// Front end: takes byte requests, tags zero bytes and queues them for the back end.
module b58_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  b58_stream_if.sink       in_i,
  output b58_pkg::b58_q_t  q_o,
  input  logic             pop_i
);
  import b58_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  b58_item_t      slot_q [QDEPTH];
  logic [PW-1:0]  wptr_q, wptr_d;
  logic [PW-1:0]  rptr_q, rptr_d;
  logic [NW-1:0]  count_q, count_d;
  logic           push, pop;
  b58_item_t      item_in;

  assign in_i.ready = (count_q != NW'(QDEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (count_q != '0);

  assign q_o.valid  = (count_q != '0);
  assign q_o.item   = slot_q[rptr_q];

  always_comb begin
    item_in.data_byte  = in_i.data.data_byte;
    item_in.final_byte = in_i.data.final_byte;
    item_in.is_zero    = (in_i.data.data_byte == 8'h00);

    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item_in;
    end
  end

endmodule

// ===== rtl/b58_back.sv =====
// Back end: folds bytes into the base-58 digit memory, then emits the characters.
module b58_back #(
  parameter int MAX_BYTES  = 32,
  parameter int MAX_DIGITS = 45
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b58_pkg::b58_q_t       q_i,
  output logic                  pop_o,
  b58_stream_if.source          out_o,
  output b58_pkg::b58_status_t  status_o
);
  import b58_pkg::*;

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int BW = $clog2(MAX_BYTES + 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_FOLD     = 6'b000010,
    ST_SCAN_RD  = 6'b000100,
    ST_SCAN_CHK = 6'b001000,
    ST_EMIT_RD  = 6'b010000,
    ST_EMIT     = 6'b100000
  } b58_state_e;

  b58_state_e     state_q, state_d;
  logic [CW-1:0]  used_q, used_d;
  logic [BW-1:0]  zrun_q, zrun_d;
  logic           seen_q, seen_d;
  logic [BW-1:0]  bytes_q, bytes_d;
  logic           ovf_q, ovf_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [7:0]     carry_q, carry_d;
  logic           fin_q, fin_d;
  logic [CW-1:0]  sig_q, sig_d;
  logic [BW-1:0]  zl_q, zl_d;
  logic           first_q, first_d;
  logic           ov_q, ov_d;
  b58_out_t       odata_q, odata_d;

  // digit memory, index 0 least significant
  logic [5:0]     mem [MAX_DIGITS];
  logic [5:0]     rdata_q;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [5:0]     wdata;

  logic [5:0]     digit;
  logic [13:0]    val;
  logic [24:0]    prod;
  logic [7:0]     quot;
  logic [13:0]    rem;
  logic [CW-1:0]  idx_n;
  logic [CW-1:0]  sig_m1;
  logic           fold_go;
  logic           obuf_free;
  logic           load, last;

  assign obuf_free = !ov_q || out_o.ready;
  assign sig_m1    = sig_q - 1'b1;
  assign idx_n     = idx_q + 1'b1;

  // one digit of digit*256 + carry, split by 58
  always_comb begin
    digit = (idx_q < used_q) ? rdata_q : 6'd0;
    val   = {digit, 8'h00} + {6'd0, carry_q};
    prod  = 25'(val) * 25'(RECIP);
    quot  = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    rem   = val - ({1'b0, quot, 5'd0} + {2'b0, quot, 4'd0}
                 + {3'b0, quot, 3'd0} + {5'b0, quot, 1'b0});
  end

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    zrun_d  = zrun_q;
    seen_d  = seen_q;
    bytes_d = bytes_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    carry_d = carry_q;
    fin_d   = fin_q;
    sig_d   = sig_q;
    zl_d    = zl_q;
    first_d = first_q;
    ov_d    = ov_q && !out_o.ready;
    odata_d = odata_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = idx_q[AW-1:0];
    wdata   = rem[5:0];
    re      = 1'b0;
    raddr   = '0;
    fold_go = 1'b0;
    load    = 1'b0;
    last    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          fin_d = q_i.item.final_byte;
          if (bytes_q < BW'(MAX_BYTES)) begin
            bytes_d = bytes_q + 1'b1;
            if (!seen_q && q_i.item.is_zero) begin
              zrun_d = zrun_q + 1'b1;
            end else begin
              seen_d  = 1'b1;
              fold_go = !q_i.item.is_zero || (used_q != '0);
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (fold_go) begin
            idx_d   = '0;
            carry_d = q_i.item.data_byte;
            re      = 1'b1;
            state_d = ST_FOLD;
          end else if (q_i.item.final_byte) begin
            sig_d   = used_q;
            zl_d    = zrun_d;
            first_d = 1'b1;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_FOLD: begin
        we = 1'b1;
        if ((idx_n < CW'(MAX_DIGITS)) && ((quot != 8'd0) || (idx_n < used_q))) begin
          idx_d   = idx_n;
          carry_d = quot;
          re      = 1'b1;
          raddr   = idx_n[AW-1:0];
        end else begin
          used_d = idx_n;
          if (fin_q) begin
            sig_d   = idx_n;
            zl_d    = zrun_q;
            first_d = 1'b1;
            state_d = ST_SCAN_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN_RD: begin
        if (sig_q == '0) begin
          state_d = ST_EMIT_RD;
        end else begin
          re      = 1'b1;
          raddr   = sig_m1[AW-1:0];
          state_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        // drop leading zero digits
        if (rdata_q == 6'd0) begin
          sig_d   = sig_m1;
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        if ((zl_q == '0) && (sig_q == '0)) begin
          used_d  = '0;
          zrun_d  = '0;
          seen_d  = 1'b0;
          bytes_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          re      = (sig_q != '0);
          raddr   = sig_m1[AW-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // the final byte carries the first character; later requests one each
        if ((first_q || q_i.valid) && obuf_free) begin
          pop_o   = !first_q;
          first_d = 1'b0;
          load    = 1'b1;
          if (zl_q != '0) begin
            odata_d.out_char = CHAR_ONE;
            zl_d = zl_q - 1'b1;
          end else begin
            odata_d.out_char = b58_char(rdata_q);
            sig_d = sig_m1;
          end
          last             = (zl_d == '0) && (sig_d == '0);
          odata_d.out_last = last;
          odata_d.overflow = ovf_q;
          ov_d             = 1'b1;
          if (last) begin
            used_d  = '0;
            zrun_d  = '0;
            seen_d  = 1'b0;
            bytes_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      zrun_q  <= '0;
      seen_q  <= 1'b0;
      bytes_q <= '0;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
      sig_q   <= '0;
      zl_q    <= '0;
      first_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      zrun_q  <= zrun_d;
      seen_q  <= seen_d;
      bytes_q <= bytes_d;
      ovf_q   <= ovf_d;
      fin_q   <= fin_d;
      sig_q   <= sig_d;
      zl_q    <= zl_d;
      first_q <= first_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    carry_q <= carry_d;
    odata_q <= odata_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = odata_q;

  assign status_o.emit_last   = load && last;
  assign status_o.idle        = (state_q == ST_IDLE);
  assign status_o.store_empty = (used_q == '0);

endmodule

// ===== rtl/base58_encoder.sv =====
// Base58 encoder (Bitcoin alphabet): top level joining the front queue and the back end.
//
// in_i carries one message byte per request, most significant first, with
// final_byte set on the last byte. out_o returns one ASCII character per
// request: after the final byte, every further input request yields one
// more character, until the one with out_last set. Input fields of those
// requests are ignored. overflow is set on every character of a message
// that had more than MAX_BYTES bytes; the extra bytes are not encoded.
// Leading zero bytes come out as '1', then the significant base-58 digits.
// In the back end each byte runs one multiply-add and divide-by-58 step
// per cycle over the live digits touched by the carry chain (at most
// MAX_DIGITS), reading one digit and writing another of the digit memory.
// On the final byte, leading zero digits are stripped by a read and a check
// step each; each character then needs a digit read, then an output load.
// A two-entry input queue keeps taking requests while the back end works.
// A single output register holds a character while out_o.ready is low; the
// back end waits on it and the input queue fills up and stalls in_i.
// Reset clears the state and all counters but the fold index; the digit memory is masked by its
// live digit count and needs no clearing.
module base58_encoder #(
  parameter int MAX_BYTES  = 32,
  parameter int MAX_DIGITS = 45
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  b58_stream_if.sink    in_i,
  b58_stream_if.source  out_o
);
  import b58_pkg::*;

  b58_q_t       q;
  logic         pop;
  b58_status_t  st;

  b58_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .q_o    (q),
    .pop_i  (pop)
  );

  b58_back #(
    .MAX_BYTES  (MAX_BYTES),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_i      (q),
    .pop_o    (pop),
    .out_o    (out_o),
    .status_o (st)
  );

`ifndef SYNTH
  a_pop_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q.valid)
    else $error("back end popped an empty queue");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.emit_last |=> (st.idle && st.store_empty))
    else $error("state not cleared after last character");

  a_last_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.emit_last |=> (out_o.valid && out_o.data.out_last))
    else $error("last character not presented");
`endif

endmodule
